>>> sv/krfl_pkg.sv
// Shared constants and types for the keyed record FIFO list.
package krfl_pkg;

	localparam int DEPTH = 16;
	localparam int KEY_W = 31;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OUT_CNT_W = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE_HEAD = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_REMOVE_KEY = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] payload;
	} record_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic del;
	} cell_ctl_t;

endpackage

>>> sv/krfl_cell.sv
// One slot of the record chain: holds a record, matches keys and shifts toward the head.
module krfl_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  krfl_pkg::cell_ctl_t ctl,
	input  krfl_pkg::record_t new_rec,
	input  logic [krfl_pkg::KEY_W-1:0] search_key,
	input  logic              prev_valid,
	input  krfl_pkg::record_t next_rec,
	input  logic              next_valid,
	input  logic              seen_in,
	output logic              seen_out,
	output logic              first_hit,
	output krfl_pkg::record_t rec,
	output logic              valid
);
	import krfl_pkg::*;

	record_t rec_q;
	logic valid_q;
	logic hit;
	logic shift;
	logic load;

	assign hit = valid_q && (rec_q.key == search_key);
	assign seen_out = seen_in | hit;
	assign first_hit = hit & ~seen_in;
	assign shift = ctl.pop | (ctl.del & seen_out);
	assign load = ctl.ins & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= next_rec;
		end else if (load) begin
			rec_q <= new_rec;
		end
	end

	assign rec = rec_q;
	assign valid = valid_q;

endmodule

>>> sv/keyed_record_fifo_list.sv
// Top level of the keyed record FIFO list: command decode, cell chain and result register.
// The result appears with done in the cycle after start is taken.
// Throughput: one operation per cycle; busy stays low, since the cells compare all keys
// and shift in the same cycle.
// Reset: arst_n clears the record count and all slot valid bits; done is low after reset.
// The receiver cannot stall, so every result is presented for exactly one cycle.
module keyed_record_fifo_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [krfl_pkg::KEY_W-1:0] key,
	input  logic [krfl_pkg::KEY_W-1:0] payload,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [krfl_pkg::KEY_W-1:0] found_key,
	output logic [krfl_pkg::KEY_W-1:0] found_payload,
	output logic [krfl_pkg::OUT_CNT_W-1:0] entry_count,
	output logic                       is_empty
);
	import krfl_pkg::*;

	logic accept;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	cell_ctl_t ctl;
	record_t new_rec;
	record_t rec [DEPTH];
	logic valid [DEPTH];
	logic seen [DEPTH+1];
	logic first_hit [DEPTH];
	record_t match_rec;
	record_t found_rec;
	logic [1:0] status_next;
	logic is_full;
	logic is_zero;
	logic any_match;

	logic done_q;
	logic [1:0] status_q;
	record_t found_q;
	logic [OUT_CNT_W-1:0] count_out_q;
	logic empty_q;

	assign busy = 1'b0;
	assign accept = start & ~busy;
	assign new_rec.key = key;
	assign new_rec.payload = payload;
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_zero = (count_q == '0);
	assign seen[0] = 1'b0;
	assign any_match = seen[DEPTH];

	assign ctl.ins = accept && (operation == OP_INSERT) && !is_full;
	assign ctl.pop = accept && (operation == OP_REMOVE_HEAD) && !is_zero;
	assign ctl.del = accept && (operation == OP_REMOVE_KEY);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic prev_v;
		logic next_v;
		record_t next_r;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_r = '0;
		end else begin : g_link
			assign next_v = valid[i+1];
			assign next_r = rec[i+1];
		end

		krfl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_rec    (new_rec),
			.search_key (key),
			.prev_valid (prev_v),
			.next_rec   (next_r),
			.next_valid (next_v),
			.seen_in    (seen[i]),
			.seen_out   (seen[i+1]),
			.first_hit  (first_hit[i]),
			.rec        (rec[i]),
			.valid      (valid[i])
		);
	end

	always_comb begin
		match_rec = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_hit[i]) begin
				match_rec = match_rec | rec[i];
			end
		end
	end

	always_comb begin
		status_next = ST_OK;
		found_rec = '0;
		count_next = count_q;
		case (operation)
			OP_INSERT: begin
				if (is_full) begin
					status_next = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE_HEAD: begin
				if (is_zero) begin
					status_next = ST_EMPTY;
				end else begin
					found_rec = rec[0];
					count_next = count_q - CNT_W'(1);
				end
			end
			OP_LOOKUP, OP_REMOVE_KEY: begin
				if (is_zero) begin
					status_next = ST_EMPTY;
				end else if (!any_match) begin
					status_next = ST_NOT_FOUND;
				end else begin
					found_rec = match_rec;
					if (operation == OP_REMOVE_KEY) begin
						count_next = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_next;
			found_q <= found_rec;
			count_out_q <= OUT_CNT_W'(count_next);
			empty_q <= (count_next == '0);
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign found_key = found_q.key;
	assign found_payload = found_q.payload;
	assign entry_count = count_out_q;
	assign is_empty = empty_q;

endmodule

>>> tb/tb_keyed_record_fifo_list.sv
// Self-checking testbench for the keyed record FIFO list, with a queue-based predictor.
module tb_keyed_record_fifo_list;
	timeunit 1ns;
	timeprecision 1ps;

	import krfl_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic [KEY_W-1:0] KEY_ABSENT = 31'd42;

	typedef struct {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] payload;
		bit               quiet;
		bit               drain;
	} list_cmd_t;

	typedef struct {
		logic [1:0]           status;
		logic [KEY_W-1:0]     found_key;
		logic [KEY_W-1:0]     found_payload;
		logic [OUT_CNT_W-1:0] entry_count;
		logic                 is_empty;
	} list_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           operation = OP_INSERT;
	logic [KEY_W-1:0]     key = '0;
	logic [KEY_W-1:0]     payload = '0;
	logic                 done;
	logic [1:0]           status;
	logic [KEY_W-1:0]     found_key;
	logic [KEY_W-1:0]     found_payload;
	logic [OUT_CNT_W-1:0] entry_count;
	logic                 is_empty;

	list_cmd_t   cmd_queue[$];
	list_reply_t reply_queue[$];
	record_t     shadow_list[$];
	list_reply_t want;
	bit          taken = 1'b0;
	int          fails = 0;

	keyed_record_fifo_list uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.key(key),
		.payload(payload),
		.done(done),
		.status(status),
		.found_key(found_key),
		.found_payload(found_payload),
		.entry_count(entry_count),
		.is_empty(is_empty)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic list_reply_t predict_reply(logic [1:0] op, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] p);
		list_reply_t r;
		record_t rec;
		int hit;
		r.status = ST_OK;
		r.found_key = '0;
		r.found_payload = '0;
		hit = -1;
		case (op)
			OP_INSERT: begin
				if (shadow_list.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					rec.key = k;
					rec.payload = p;
					shadow_list.push_back(rec);
				end
			end
			OP_REMOVE_HEAD: begin
				if (shadow_list.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					rec = shadow_list.pop_front();
					r.found_key = rec.key;
					r.found_payload = rec.payload;
				end
			end
			default: begin
				if (shadow_list.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					foreach (shadow_list[i])
						if (hit < 0 && shadow_list[i].key == k)
							hit = i;
					if (hit < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.found_key = shadow_list[hit].key;
						r.found_payload = shadow_list[hit].payload;
						if (op == OP_REMOVE_KEY)
							shadow_list.delete(hit);
					end
				end
			end
		endcase
		r.entry_count = OUT_CNT_W'(shadow_list.size());
		r.is_empty = (shadow_list.size() == 0);
		return r;
	endfunction

	function automatic void queue_cmd(logic [1:0] op, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] p);
		list_cmd_t c;
		c.op = op;
		c.key = k;
		c.payload = p;
		c.quiet = 1'b0;
		c.drain = 1'b0;
		cmd_queue.push_back(c);
	endfunction

	// The driver drops the front command once the previous rising edge took it.
	always @(negedge clk) begin
		if (taken)
			void'(cmd_queue.pop_front());
		if (!arst_n || cmd_queue.size() == 0) begin
			start <= 1'b0;
		end else if (cmd_queue[0].drain && reply_queue.size() != 0) begin
			start <= 1'b0;
		end else if (!cmd_queue[0].quiet && $urandom_range(99) < 14) begin
			start <= 1'b0;
		end else begin
			start <= 1'b1;
			operation <= cmd_queue[0].op;
			key <= cmd_queue[0].key;
			payload <= cmd_queue[0].payload;
		end
	end

	always @(posedge clk) begin
		taken = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (reply_queue.size() == 0) begin
					$error("Result transfer with no command outstanding.");
					fails++;
				end else begin
					want = reply_queue.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (found_key !== want.found_key) begin
						$error("found_key: expected %0d, got %0d", want.found_key, found_key);
						fails++;
					end
					if (found_payload !== want.found_payload) begin
						$error("found_payload: expected %0d, got %0d", want.found_payload,
							found_payload);
						fails++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							entry_count);
						fails++;
					end
					if (is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				reply_queue.push_back(predict_reply(operation, key, payload));
				taken = 1'b1;
			end
		end
	end

	initial begin
		#400us;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] key_pool[6];
		logic [KEY_W-1:0] k;
		logic [1:0] op;
		int n_rand;
		int phase;
		int phase_len;
		int insert_weight;
		n_rand = 0;
		phase = 0;

		queue_cmd(OP_REMOVE_HEAD, '0, '0);
		queue_cmd(OP_LOOKUP, KEY_ABSENT, '0);
		queue_cmd(OP_REMOVE_KEY, KEY_ABSENT, '0);
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0 || i == 3)
				k = '0;
			else if (i == 1)
				k = KEY_MAX;
			else
				k = KEY_W'(i * 1000 + 7);
			queue_cmd(OP_INSERT, k, (i == 0) ? KEY_MAX : KEY_W'(i));
		end
		queue_cmd(OP_INSERT, 31'd99, 31'd99);
		queue_cmd(OP_LOOKUP, '0, '0);
		queue_cmd(OP_LOOKUP, KEY_ABSENT, '0);
		queue_cmd(OP_REMOVE_KEY, KEY_ABSENT, '0);
		queue_cmd(OP_REMOVE_KEY, 31'd5007, '0);
		queue_cmd(OP_REMOVE_HEAD, '0, '0);

		// Phases alternate between filling and draining, with keys drawn mostly from a
		// small pool so that hits and duplicates are common.
		while (n_rand < 1375) begin
			phase_len = $urandom_range(30, 80);
			insert_weight = phase[0] ? 25 : 65;
			foreach (key_pool[i])
				key_pool[i] = KEY_W'($urandom());
			for (int j = 0; j < phase_len; j++) begin
				if ($urandom_range(99) < insert_weight)
					op = OP_INSERT;
				else
					op = 2'($urandom_range(3, 1));
				if ($urandom_range(99) < 85)
					k = key_pool[$urandom_range(5)];
				else
					k = KEY_W'($urandom());
				queue_cmd(op, k, KEY_W'($urandom()));
				if (n_rand >= 500 && n_rand < 800)
					cmd_queue[$].quiet = 1'b1;
				if (n_rand == 0 || n_rand == 1000)
					cmd_queue[$].drain = 1'b1;
				n_rand++;
			end
			phase++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() != 0 || reply_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
